// ----- rtl/group_bitmap_next_fit_allocator_assert.svh -----
// Assertion macros for the group bitmap allocator.
// Each checks on the rising clock edge and is off while reset is low.
`ifndef GROUP_BITMAP_NEXT_FIT_ALLOCATOR_ASSERT_SVH
`define GROUP_BITMAP_NEXT_FIT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GBNF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GBNF_ASSERT_SAME(lbl, ante, cons, msg)
`define GBNF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/gbnf_pkg.sv -----
package gbnf_pkg;

  localparam int GrpW   = 11;            // group number width
  localparam int CntW   = 12;            // group count width
  localparam int WordW  = 32;            // bitmap word width
  localparam int BitW   = 5;             // bit index within a word
  localparam int AddrW  = GrpW - BitW;   // bitmap word address
  localparam int WordsN = 1 << AddrW;    // bitmap words
  localparam int NW     = BitW + 1;      // groups probed in one word (1..32)

  localparam logic [CntW-1:0] MaxGroups   = 12'd2048;
  localparam logic [CntW-1:0] WordGroups  = 12'd32;
  localparam logic [CntW-1:0] TotalReset  = 12'd2048;
  localparam logic [GrpW-1:0] FirstReset  = 11'd2;
  localparam logic [CntW-1:0] PtrReset    = 12'hFFF;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_TOTAL = 2'd0,
    REG_FIRST = 2'd1,
    REG_RSVD2 = 2'd2,
    REG_RSVD3 = 2'd3
  } reg_e;

  typedef logic [GrpW-1:0] grp_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [WordW-1:0] word_t;

endpackage

// ----- rtl/gbnf_ram.sv -----
module gbnf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/group_bitmap_next_fit_allocator.sv -----
// Group bitmap next-fit allocator: one used/free bit per allocation group and
// a rotating search pointer.
// Channels: the request channel (in_valid_i/in_ready_o) carries a mode and a
// group; each request gives exactly one word on the result channel
// (out_valid_o/out_ready_i). The config channel writes the group count
// (index 0) and the first data group (index 1); it is always ready and must
// only be used while the block is idle.
// Timing: in_ready_o is high only while idle. Clear goes from accept to the
// final state and the result word; mark passes the read-modify-write state on
// the way; allocate scans 32-bit bitmap words, up to 65 on a full wrapped sweep.
// The single bitmap RAM read port sets the scan rate, one word per cycle.
// Reset: all groups free (per-word valid flags, no clearing pass), pointer
// all ones so the first search starts at the first data group, registers at
// 2048 groups and first data group 2.
// Stall: the result sits in an output register; a new request is taken while
// it waits, and a finished request holds in its final state until the output
// register is free.
module group_bitmap_next_fit_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [11:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_mode_i,
  input  gbnf_pkg::grp_t       in_group_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gbnf_pkg::grp_t       out_granted_group_o,
  output logic                 out_granted_o
);
  import gbnf_pkg::*;

  `include "group_bitmap_next_fit_allocator_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;   // read-modify-write of one word
  localparam logic [1:0] ST_SCAN = 2'd2;   // one bitmap word per cycle
  localparam logic [1:0] ST_FIN  = 2'd3;   // wait for output register

  logic [1:0] state_q, state_d;

  cnt_t total_q;
  grp_t first_q;
  cnt_t ptr_q, ptr_d;
  grp_t g_q, g_d;                 // current probe position
  cnt_t rem_q, rem_d;             // probes left
  logic res_granted_q, res_granted_d;
  grp_t res_group_q, res_group_d;
  logic out_valid_q;
  logic out_granted_q;
  grp_t out_group_q;

  logic [WordsN-1:0] row_valid_q;  // word never written since clear reads as 0
  logic              rd_valid_q;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  word_t            wdata, rdata, word;

  cnt_t cnt;
  logic in_fire, fin_load, clear_rows;

  // scan datapath
  cnt_t          word_end, lim, n_full, g_sum;
  logic [NW-1:0] n;
  logic [BitW-1:0] bitpos, k_abs, off;
  word_t         free_bits;
  logic          found, hit, last;
  grp_t          g_next, g_start;

  assign cnt = (total_q > MaxGroups) ? MaxGroups : total_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign fin_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign clear_rows  = in_fire && (in_mode_i == MODE_CLEAR);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
      first_q <= FirstReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TOTAL: total_q <= cfg_data_i;
        REG_FIRST: first_q <= cfg_data_i[GrpW-1:0];
        default: ;
      endcase
    end
  end

  gbnf_ram #(
    .Width(WordW),
    .Depth(WordsN)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign word = rd_valid_q ? rdata : '0;

  // first free group at or after the probe position within this word
  assign bitpos    = g_q[BitW-1:0];
  assign free_bits = ~word & ({WordW{1'b1}} << bitpos);

  always_comb begin
    found = 1'b0;
    k_abs = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found = 1'b1;
        k_abs = BitW'(i);
      end
    end
  end

  assign word_end = {1'b0, g_q[GrpW-1:BitW], {BitW{1'b0}}} + WordGroups;
  assign lim      = (word_end < cnt) ? word_end : cnt;
  assign n_full   = lim - {1'b0, g_q};
  assign n        = n_full[NW-1:0];
  assign off      = k_abs - bitpos;
  assign hit      = found && ({1'b0, off} < n) && ({{(CntW-BitW){1'b0}}, off} < rem_q);
  assign last     = rem_q <= {{(CntW-NW){1'b0}}, n};
  assign g_sum    = {1'b0, g_q} + {{(CntW-NW){1'b0}}, n};
  assign g_next   = (g_sum >= cnt) ? first_q : g_sum[GrpW-1:0];
  assign g_start  = (ptr_q >= cnt) ? first_q : ptr_q[GrpW-1:0];

  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    g_d           = g_q;
    rem_d         = rem_q;
    res_granted_d = res_granted_q;
    res_group_d   = res_group_q;
    we            = 1'b0;
    waddr         = g_q[GrpW-1:BitW];
    wdata         = word;
    raddr         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_granted_d = 1'b0;
          res_group_d   = '0;
          state_d       = ST_FIN;
          case (in_mode_i)
            MODE_MARK: begin
              g_d   = in_group_i;
              raddr = in_group_i[GrpW-1:BitW];
              if ((in_group_i != '0) && ({1'b0, in_group_i} < cnt)) begin
                state_d = ST_MARK;
              end
            end
            MODE_ALLOC: begin
              g_d   = g_start;
              rem_d = cnt - {1'b0, first_q};
              raddr = g_start[GrpW-1:BitW];
              if ({1'b0, first_q} < cnt) begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        we      = 1'b1;
        wdata   = word | (word_t'(1) << bitpos);
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        raddr = g_next[GrpW-1:BitW];
        if (hit) begin
          we            = 1'b1;
          wdata         = word | (word_t'(1) << k_abs);
          res_granted_d = 1'b1;
          res_group_d   = {g_q[GrpW-1:BitW], k_abs};
          ptr_d         = {1'b0, g_q[GrpW-1:BitW], k_abs} + 12'd1;
          state_d       = ST_FIN;
        end else if (last) begin
          state_d = ST_FIN;
        end else begin
          rem_d = rem_q - {{(CntW-NW){1'b0}}, n};
          g_d   = g_next;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= PtrReset;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      rd_valid_q <= row_valid_q[raddr];
      if (clear_rows) begin
        row_valid_q <= '0;
      end else if (we) begin
        row_valid_q[waddr] <= 1'b1;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    g_q           <= g_d;
    rem_q         <= rem_d;
    res_granted_q <= res_granted_d;
    res_group_q   <= res_group_d;
    if (fin_load) begin
      out_granted_q <= res_granted_q;
      out_group_q   <= res_group_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_granted_o       = out_granted_q;
  assign out_granted_group_o = out_group_q;

  `GBNF_ASSERT_SAME(a_fail_zero, out_valid_o && !out_granted_o,
                    out_granted_group_o == '0, "failed result carries a group")
  `GBNF_ASSERT_SAME(a_scan_bounds, state_q == ST_SCAN,
                    (rem_q != '0) && ({1'b0, g_q} < cnt), "scan out of bounds")
  `GBNF_ASSERT_NEXT(a_ptr_follows, fin_load && res_granted_q,
                    ptr_q == ({1'b0, out_granted_group_o} + 12'd1),
                    "pointer not just past granted group")

endmodule
